FILE: sv/lfuc_pkg.sv
`timescale 1ns / 1ps
package lfuc_pkg;
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int CAP_W      = 5;
   localparam int MIN_CAP    = 4;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int RANK_W     = $clog2(ENTRIES);
   localparam int NUM_W      = $clog2(ENTRIES + 1);
   localparam int CMP_W      = ((NUM_W > CAP_W) ? NUM_W : CAP_W) + 1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic decide;
      logic touch;
      logic fill;
      logic scan_clear;
      logic scan_step;
      logic evict;
   } ctl_type;

   typedef struct packed {
      logic hit;
      logic is_set;
      logic room;
      logic scan_last;
   } sts_type;
endpackage

FILE: sv/lfuc_datapath.sv
`timescale 1ns / 1ps
module lfuc_datapath import lfuc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_write,
   input  logic [CAP_W-1:0] csr_data,
   input  ctl_type          ctl,
   output sts_type          sts,
   output rsp_type          rsp_data
);
   logic [CAP_W-1:0]      cap_ff, cap_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff [ENTRIES];
   logic [KEY_BITS-1:0]   key_in [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];
   logic [COUNT_BITS-1:0] count_in [ENTRIES];
   logic [RANK_W-1:0]     rank_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_in [ENTRIES];
   logic [NUM_W-1:0]      num_ff, num_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  have_ff, have_in;
   logic [IDX_W-1:0]      best_ff, best_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [RANK_W-1:0]     best_rank_ff, best_rank_in;

   logic                  m_found;
   logic [IDX_W-1:0]      m_idx, f_idx;
   logic [IDX_W-1:0]      sel;
   logic [RANK_W-1:0]     drop_r, top_rank;
   logic [CMP_W-1:0]      eff_cap, num_ext;

   assign sel      = ctl.scan_step ? idx_ff : slot_ff;
   assign drop_r   = ctl.touch ? rank_ff[sel] : best_rank_ff;
   assign top_rank = RANK_W'(num_ff - NUM_W'(1));
   assign num_ext  = CMP_W'(num_ff);

   always_comb begin
      if (CMP_W'(cap_ff) < CMP_W'(MIN_CAP)) eff_cap = CMP_W'(MIN_CAP);
      else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) eff_cap = CMP_W'(ENTRIES);
      else eff_cap = CMP_W'(cap_ff);
   end

   // first matching and first free entries
   always_comb begin
      m_found = 1'b0;
      m_idx   = '0;
      f_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key) begin
            m_found = 1'b1;
            m_idx   = IDX_W'(i);
         end
         if (!valid_ff[i]) f_idx = IDX_W'(i);
      end
   end

   always_comb begin
      cap_in       = csr_write ? csr_data : cap_ff;
      req_in       = ctl.load ? req_data : req_ff;
      rsp_in       = rsp_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      free_in      = free_ff;
      idx_in       = idx_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_cnt_in  = best_cnt_ff;
      best_rank_in = best_rank_ff;
      valid_in     = valid_ff;
      num_in       = num_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;

      if (ctl.lookup) begin
         hit_in  = m_found;
         slot_in = m_idx;
         free_in = f_idx;
      end
      if (ctl.decide) begin
         rsp_in.hit        = hit_ff;
         rsp_in.read_value = (hit_ff && req_ff.cmd == CMD_GET) ? value_ff[sel] : '0;
      end
      if (ctl.scan_clear) begin
         idx_in  = '0;
         have_in = 1'b0;
      end
      if (ctl.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (valid_ff[sel] && (!have_ff || count_ff[sel] < best_cnt_ff ||
             (count_ff[sel] == best_cnt_ff && rank_ff[sel] < best_rank_ff))) begin
            have_in      = 1'b1;
            best_in      = sel;
            best_cnt_in  = count_ff[sel];
            best_rank_in = rank_ff[sel];
         end
      end
      if (ctl.touch || ctl.evict) begin
         for (int i = 0; i < ENTRIES; i++)
            if (valid_ff[i] && rank_ff[i] > drop_r) rank_in[i] = rank_ff[i] - RANK_W'(1);
      end
      if (ctl.touch) begin
         rank_in[slot_ff] = top_rank;
         if (count_ff[slot_ff] != '1) count_in[slot_ff] = count_ff[slot_ff] + COUNT_BITS'(1);
         if (req_ff.cmd == CMD_SET) value_in[slot_ff] = req_ff.write_value;
      end
      if (ctl.fill) begin
         valid_in[free_ff] = 1'b1;
         num_in            = num_ff + NUM_W'(1);
         rank_in[free_ff]  = RANK_W'(num_ff);
         key_in[free_ff]   = req_ff.key;
         value_in[free_ff] = req_ff.write_value;
         count_in[free_ff] = COUNT_BITS'(1);
      end
      if (ctl.evict) begin
         rank_in[best_ff]  = top_rank;
         key_in[best_ff]   = req_ff.key;
         value_in[best_ff] = req_ff.write_value;
         count_in[best_ff] = COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(MIN_CAP);
         valid_ff <= '0;
         num_ff   <= '0;
      end else begin
         cap_ff   <= cap_in;
         valid_ff <= valid_in;
         num_ff   <= num_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      free_ff      <= free_in;
      idx_ff       <= idx_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      best_cnt_ff  <= best_cnt_in;
      best_rank_ff <= best_rank_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      count_ff     <= count_in;
      rank_ff      <= rank_in;
   end

   assign sts.hit       = hit_ff;
   assign sts.is_set    = (req_ff.cmd == CMD_SET);
   assign sts.room      = num_ext < eff_cap;
   assign sts.scan_last = (idx_ff == IDX_W'(ENTRIES - 1));
   assign rsp_data      = rsp_ff;
endmodule

FILE: sv/lfuc_controller.sv
`timescale 1ns / 1ps
module lfuc_controller import lfuc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_EVICT  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl.lookup = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            ctl.decide = 1'b1;
            state_in   = ST_RESP;
            if (sts.hit) ctl.touch = 1'b1;
            else if (sts.is_set && sts.room) ctl.fill = 1'b1;
            else if (sts.is_set) begin
               ctl.scan_clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            ctl.evict = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

FILE: sv/lfu_cache_count_recency.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_data: cmd, key, write_value
// rsp       out        rsp_valid/rsp_ready    rsp_data: hit, read_value
// csr       in         csr_valid/csr_ready    csr_data: capacity
//
// Hits, get misses and fills go through the lookup and decide states before response valid.
// An eviction scans all entries one per cycle for the victim, then goes through an evict state.
// One request at a time; the next is taken once the response is transferred.
// Reset clears the valid bits at once, capacity returns to four.
module lfu_cache_count_recency import lfuc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);
   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   lfuc_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .ctl(ctl)
   );

   lfuc_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_data),
      .csr_write(csr_valid), .csr_data(csr_data),
      .ctl(ctl), .sts(sts), .rsp_data(rsp_data)
   );
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import lfuc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = ENTRIES + 12;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   lfu_cache_count_recency i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the cache
   logic                  shadow_valid [ENTRIES];
   logic [KEY_BITS-1:0]   shadow_key   [ENTRIES];
   logic [VALUE_BITS-1:0] shadow_value [ENTRIES];
   logic [COUNT_BITS-1:0] shadow_count [ENTRIES];
   int                    shadow_rank  [ENTRIES];
   logic [CAP_W-1:0]      shadow_cap;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int  mismatches = 0;
   int  reqs_sent = 0;
   int  rsps_seen = 0;
   int  hits_seen = 0;
   int  evictions = 0;
   bit  quiet = 1'b0;
   bit  req_taken = 1'b0;
   int  req_gap = 0;
   int  rdy_gap = 0;
   int  hold_left = 0;
   int  stall_cycles = 0;

   task automatic close_rank_gap(input int r);
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
   endtask

   task automatic predict_access(input req_type rq);
      int      used;
      int      slot;
      int      cap;
      bit      found;
      bit      have;
      rsp_type rs;
      used = 0;
      slot = 0;
      found = 1'b0;
      have = 1'b0;
      rs = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_valid[i]) begin
            used++;
            if (!found && shadow_key[i] == rq.key) begin
               found = 1'b1;
               slot = i;
            end
         end
      end
      if (found) begin
         close_rank_gap(shadow_rank[slot]);
         shadow_rank[slot] = used - 1;
         if (shadow_count[slot] != '1) shadow_count[slot]++;
         rs.hit = 1'b1;
         if (rq.cmd == CMD_SET) shadow_value[slot] = rq.write_value;
         else rs.read_value = shadow_value[slot];
      end else if (rq.cmd == CMD_SET) begin
         cap = (shadow_cap < MIN_CAP) ? MIN_CAP : shadow_cap;
         if (cap > ENTRIES) cap = ENTRIES;
         if (used < cap) begin
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!shadow_valid[i]) slot = i;
            shadow_rank[slot] = used;
            shadow_valid[slot] = 1'b1;
         end else begin
            // lowest count wins, least recent on a tie
            for (int i = 0; i < ENTRIES; i++) begin
               if (shadow_valid[i] && (!have || shadow_count[i] < shadow_count[slot] ||
                   (shadow_count[i] == shadow_count[slot] &&
                    shadow_rank[i] < shadow_rank[slot]))) begin
                  slot = i;
                  have = 1'b1;
               end
            end
            close_rank_gap(shadow_rank[slot]);
            shadow_rank[slot] = used - 1;
            evictions++;
         end
         shadow_key[slot] = rq.key;
         shadow_value[slot] = rq.write_value;
         shadow_count[slot] = 1;
      end
      expected_rsps.push_back(rs);
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch %s: expected hit=%0b value=%h, got hit=%0b value=%h",
                  $realtime, what, want.hit, want.read_value, got.hit, got.read_value);
   endtask

   // monitor: sample transfers at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      req_taken = 1'b0;
      if (reset) begin
         shadow_cap = MIN_CAP;
         for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
      end else begin
         if (csr_valid && csr_ready) shadow_cap = csr_data;
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            reqs_sent++;
            predict_access(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            rsps_seen++;
            if (rsp_data.hit) hits_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (want.hit !== rsp_data.hit)
                  report_mismatch("hit", want, rsp_data);
               else if (want.read_value !== rsp_data.read_value)
                  report_mismatch("read_value", want, rsp_data);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rdy_gap > 0) begin
         rdy_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) rdy_gap = $urandom_range(1, 6);
      end
   end

   task automatic queue_req(input logic cmd, input logic [KEY_BITS-1:0] k,
                            input logic [VALUE_BITS-1:0] v);
      req_type rq;
      rq.cmd = cmd;
      rq.key = k;
      rq.write_value = v;
      pending_reqs.push_back(rq);
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_data <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly keys from a small pool so hits and evictions are frequent
   task automatic random_traffic(input int count, input int pool_size);
      logic [KEY_BITS-1:0] pool[$];
      logic [KEY_BITS-1:0] k;
      pool.push_back('0);
      pool.push_back('1);
      for (int i = 2; i < pool_size; i++) pool.push_back($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) k = $urandom;
         else k = pool[$urandom_range(0, pool_size - 1)];
         queue_req($urandom_range(0, 1) ? CMD_SET : CMD_GET, k, $urandom);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_capacity(4);
      queue_req(CMD_GET, 32'h0, 32'hFFFF_FFFF);        // miss on empty cache
      queue_req(CMD_SET, 32'h0, 32'h0);
      queue_req(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(CMD_GET, 32'h0, 32'h1234_5678);
      queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      queue_req(CMD_SET, 32'h0, 32'hA5A5_5A5A);        // set hit replaces value
      queue_req(CMD_GET, 32'h0, 32'h0);
      queue_req(CMD_SET, 32'h11, 32'h1);
      queue_req(CMD_SET, 32'h22, 32'h2);               // cache full
      queue_req(CMD_SET, 32'h33, 32'h3);               // evicts lowest count
      queue_req(CMD_GET, 32'h11, 32'h0);
      queue_req(CMD_SET, 32'h44, 32'h4);               // tie at count 1, least recent goes
      queue_req(CMD_GET, 32'h33, 32'h0);
      queue_req(CMD_GET, 32'h44, 32'h0);
      queue_req(CMD_GET, 32'h22, 32'h0);
      queue_req(CMD_SET, 32'h55, 32'h5);
      queue_req(CMD_GET, 32'h0, 32'h0);
      queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      drain();

      write_capacity(16);
      random_traffic(250, 24);
      // long receiver stall while requests keep coming
      repeat (20) @(posedge clock);
      hold_left = 300;
      random_traffic(250, 24);
      drain();

      write_capacity(0);                                // below minimum, entries kept
      random_traffic(300, 10);
      drain();

      write_capacity(31);                               // above entry count
      random_traffic(400, 22);
      drain();

      write_capacity(CAP_W'($urandom_range(5, 15)));
      random_traffic(400, 16);
      drain();

      write_capacity(4);
      random_traffic(400, 7);
      drain();

      // one hot key, then churn the other entries around it
      quiet = 1'b1;
      queue_req(CMD_SET, 32'hCAFE_0001, 32'h600D);
      for (int i = 0; i < 40; i++)
         queue_req(CMD_GET, 32'hCAFE_0001, 32'h0);
      for (int i = 0; i < 6; i++) queue_req(CMD_SET, $urandom, $urandom);
      queue_req(CMD_GET, 32'hCAFE_0001, 32'h0);
      drain();

      $display("%0d requests, %0d responses, %0d hits, %0d evictions; capacities 4, 16, 0, 31",
               reqs_sent, rsps_seen, hits_seen, evictions);
      $display("and mid-range, receiver backpressure, a hot key under churn");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
